/* rtl/core/wgo_pkg.sv */
// Shared types, constants and helper functions for the wheel and gyro odometry tracker.
// Used by wgo_cordic and wheel_gyro_odometry_tracker; depends on nothing else.
`default_nettype none

package wgo_pkg;

    localparam int ROTATION_STEPS = 16;
    localparam int STEP_W         = (ROTATION_STEPS > 1) ? $clog2(ROTATION_STEPS) : 1;

    // Angles are 1/256 degree; a full turn and a quarter turn.
    localparam int TURN    = 92160;
    localparam int QUARTER = 23040;

    // pi/2880 as TRAVEL_K / 2^40, CORDIC start length in Q30, 1/45 as RECIP / 2^27.
    localparam logic [32:0] TRAVEL_K    = 33'd1199381129;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam logic [32:0] MOD_RECIP   = 33'd2982616;

    localparam logic [8:0] BLEND_FULL = 9'd256;

    typedef enum logic [2:0] {
        CFG_LEFT_RADIUS  = 3'd0,
        CFG_RIGHT_RADIUS = 3'd1,
        CFG_BACK_RADIUS  = 3'd2,
        CFG_DRIVE_PAIR   = 3'd3,
        CFG_FIX_BLEND    = 3'd4
    } t_cfg_idx;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_FUSE  = 2'd1;
    localparam logic [1:0] PH_ENDED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MODM,
        S_MODF,
        S_BLEND,
        S_TA,
        S_TW,
        S_TL,
        S_TH,
        S_TE1,
        S_TE2,
        S_FWD,
        S_CORD,
        S_ROT,
        S_DRAIN,
        S_DONE
    } t_state;

    // What to do with the product when it comes out of the multiplier register.
    typedef enum logic [3:0] {
        TAG_NONE,
        TAG_TMAG,
        TAG_LOAD,
        TAG_ADDHI,
        TAG_RLOAD,
        TAG_RX,
        TAG_RY,
        TAG_BX,
        TAG_BY
    } t_tag;

    function automatic logic signed [26:0] atan_val(input logic [4:0] idx);
        logic signed [26:0] v;
        case (idx)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sh0080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/wgo_cordic.sv */
// Iterative CORDIC rotation: one micro-rotation per cycle.
// Depends on wgo_pkg for the step count, start length and arctangent table.
`default_nettype none

module wgo_cordic
    import wgo_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire signed [17:0]   i_angle,
    output logic                o_done,
    output logic signed [31:0]  o_cos,
    output logic signed [31:0]  o_sin
);

    logic                r_run;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_y;
    logic signed [26:0]  r_z;

    logic [4:0]          sh;
    logic signed [31:0]  dx;
    logic signed [31:0]  dy;
    logic signed [26:0]  at;

    always_comb begin
        sh = 5'(r_cnt);
        dx = r_y >>> sh;
        dy = r_x >>> sh;
        at = atan_val(sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                if (r_cnt == STEP_W'(ROTATION_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= {i_angle[17], i_angle, 8'd0};
        end else if (r_run) begin
            // rotate toward zero residual angle
            if (!r_z[26]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;

endmodule

`default_nettype wire

/* rtl/core/wheel_gyro_odometry_tracker.sv */
// Sequence: a seed beat goes through the heading modulo states to the output register; a tick
// also runs the fix blend (while fusing), wheel travel and rotation steps, paced by the shared
// 33x33 multiplier (14 products, 2 more while fusing) and the ROTATION_STEPS CORDIC iterations.
// Throughput: one item at a time; ready is high only when the sequencer is idle.
// Reset (synchronous, active low) restores register defaults and clears pose,
// encoder history, heading, held forward motion and fusion phase.
`default_nettype none

module wheel_gyro_odometry_tracker
    import wgo_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [2:0]           i_cfg_index,
    input  wire [15:0]          i_cfg_data,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire                 i_command,
    input  wire signed [31:0]   i_left_angle,
    input  wire signed [31:0]   i_right_angle,
    input  wire signed [31:0]   i_back_angle,
    input  wire signed [31:0]   i_gyro_angle,
    input  wire                 i_fix_good,
    input  wire signed [31:0]   i_fix_x,
    input  wire signed [31:0]   i_fix_y,
    input  wire signed [31:0]   i_fix_angle,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_heading_out,
    output logic                o_heading_write,
    output logic                o_moved
);

    t_state r_state, n_state;
    logic [1:0] r_idx, n_idx;

    // configuration
    logic [15:0] r_rad [3];
    logic        r_dp;
    logic [8:0]  r_blend;

    // tracked state
    logic signed [31:0] r_tx, r_ty, r_held;
    logic signed [31:0] r_last [3];
    logic signed [17:0] r_lh;
    logic [1:0]         r_phase;

    // captured beat and working registers
    logic               r_cmd, r_fuse, r_flip;
    logic signed [31:0] r_enc [3];
    logic signed [31:0] r_fx, r_fy, r_angle;
    logic signed [17:0] r_h;
    logic [49:0]        r_m;
    logic signed [31:0] r_trav [3];
    logic signed [65:0] r_prod;
    t_tag               r_tag, n_tag;
    logic signed [81:0] r_acc;

    logic               r_ovalid, r_ohw, r_omv;
    logic signed [31:0] r_ox, r_oy, r_oang;

    logic signed [32:0] mul_a, mul_b;
    logic               cord_start, cord_done;
    logic signed [31:0] cord_cos, cord_sin;

    logic               accept, fuse_c, three, out_free;
    logic signed [31:0] enc_w, last_w;
    logic [15:0]        rad_w;
    logic signed [32:0] delta_w;
    logic [8:0]         blend_eff;

    logic [31:0]        a_abs;
    logic [15:0]        q;
    logic [33:0]        rem0, rem1;
    logic signed [17:0] h_new;

    logic signed [18:0] hdiff;
    logic signed [17:0] mid, t0, t_red;
    logic               flip_c;

    logic [81:0]        rsum;
    logic [41:0]        rr;
    logic signed [31:0] trav_v;

    logic signed [32:0] cos_v, sin_v;
    logic signed [32:0] fwd_sum;
    logic signed [81:0] rot_sum;
    logic signed [81:0] rot_sh;
    logic signed [65:0] bl_sh;

    wgo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (t_red),
        .o_done  (cord_done),
        .o_cos   (cord_cos),
        .o_sin   (cord_sin)
    );

    assign accept   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign fuse_c   = !i_command && (r_phase == PH_FUSE) && i_fix_good;
    assign three    = (r_idx != 2'd2);

    always_comb begin
        case (r_idx)
            2'd0: begin
                enc_w = r_enc[0]; last_w = r_last[0]; rad_w = r_rad[0];
            end
            2'd1: begin
                enc_w = r_enc[1]; last_w = r_last[1]; rad_w = r_rad[1];
            end
            default: begin
                enc_w = r_enc[2]; last_w = r_last[2]; rad_w = r_rad[2];
            end
        endcase
        delta_w   = 33'(enc_w) - 33'(last_w);
        blend_eff = (r_blend > BLEND_FULL) ? BLEND_FULL : r_blend;
    end

    // heading remainder by a full turn, sign of the angle
    always_comb begin
        a_abs = r_angle[31] ? 32'(-r_angle) : 32'(r_angle);
        q     = r_prod[42:27];
        rem0  = {2'b00, a_abs} - 34'(q) * 34'(TURN);
        rem1  = (rem0 >= 34'(TURN)) ? rem0 - 34'(TURN) : rem0;
        h_new = r_angle[31] ? -18'(rem1) : 18'(rem1);
    end

    // mid-step heading folded into the CORDIC range
    always_comb begin
        hdiff  = 19'(r_h) - 19'(r_lh);
        mid    = r_lh + 18'(hdiff >>> 1);
        t0     = mid[17] ? mid + 18'(TURN) : mid;
        flip_c = 1'b0;
        if (t0 > 18'(QUARTER) && t0 < 18'(3 * QUARTER)) begin
            t_red  = t0 - 18'(2 * QUARTER);
            flip_c = 1'b1;
        end else if (t0 >= 18'(3 * QUARTER)) begin
            t_red = t0 - 18'(TURN);
        end else begin
            t_red = t0;
        end
    end

    // wheel travel rounding and saturation
    always_comb begin
        rsum = 82'(r_acc) + (three ? (82'd1 << 41) : (82'd1 << 39));
        rr   = three ? 42'(rsum >> 42) : rsum[81:40];
        if (delta_w[32]) begin
            trav_v = (rr >= 42'h0_8000_0000) ? 32'sh80000000 : -32'(rr);
        end else begin
            trav_v = (rr >= 42'h0_8000_0000) ? 32'sh7FFFFFFF : 32'(rr);
        end
    end

    always_comb begin
        cos_v   = r_flip ? -33'(cord_cos) : 33'(cord_cos);
        sin_v   = r_flip ? -33'(cord_sin) : 33'(cord_sin);
        fwd_sum = 33'(r_trav[0]) + 33'(r_trav[1]);
        rot_sum = (r_tag == TAG_RY) ? r_acc - 82'(r_prod) : r_acc + 82'(r_prod);
        rot_sh  = rot_sum >>> 30;
        bl_sh   = r_prod >>> 8;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_MODM;
            S_MODM:  n_state = S_MODF;
            S_MODF: begin
                n_idx = 2'd0;
                if (r_cmd) begin
                    n_state = S_DONE;
                end else if (r_fuse) begin
                    n_state = S_BLEND;
                end else begin
                    n_state = S_TA;
                end
            end
            S_BLEND: begin
                if (r_idx == 2'd1) begin
                    n_state = S_TA;
                    n_idx   = 2'd0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            S_TA:  n_state = S_TW;
            S_TW:  n_state = S_TL;
            S_TL:  n_state = S_TH;
            S_TH:  n_state = S_TE1;
            S_TE1: n_state = S_TE2;
            S_TE2: begin
                if (r_idx == 2'd2) begin
                    n_state = S_FWD;
                    n_idx   = 2'd0;
                end else begin
                    n_state = S_TA;
                    n_idx   = r_idx + 2'd1;
                end
            end
            S_FWD:  n_state = S_CORD;
            S_CORD: begin
                if (cord_done) begin
                    n_state = S_ROT;
                    n_idx   = 2'd0;
                end
            end
            S_ROT: begin
                if (r_idx == 2'd3) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // multiplier operand selection and product tagging
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        n_tag      = TAG_NONE;
        cord_start = 1'b0;
        case (r_state)
            S_MODM: begin
                mul_a = 33'(a_abs[31:11]);
                mul_b = MOD_RECIP;
            end
            S_BLEND: begin
                mul_b = 33'(blend_eff);
                if (r_idx == 2'd0) begin
                    mul_a = 33'(r_fx) - 33'(r_tx);
                    n_tag = TAG_BX;
                end else begin
                    mul_a = 33'(r_fy) - 33'(r_ty);
                    n_tag = TAG_BY;
                end
            end
            S_TA: begin
                mul_a = delta_w;
                mul_b = 33'(rad_w);
                n_tag = TAG_TMAG;
            end
            S_TL: begin
                mul_a = 33'(r_m[24:0]);
                mul_b = TRAVEL_K;
                n_tag = TAG_LOAD;
            end
            S_TH: begin
                mul_a = 33'(r_m[49:25]);
                mul_b = TRAVEL_K;
                n_tag = TAG_ADDHI;
            end
            S_FWD: cord_start = 1'b1;
            S_ROT: begin
                case (r_idx)
                    2'd0: begin
                        mul_a = 33'(r_held); mul_b = sin_v; n_tag = TAG_RLOAD;
                    end
                    2'd1: begin
                        mul_a = 33'(r_trav[2]); mul_b = cos_v; n_tag = TAG_RX;
                    end
                    2'd2: begin
                        mul_a = 33'(r_held); mul_b = cos_v; n_tag = TAG_RLOAD;
                    end
                    default: begin
                        mul_a = 33'(r_trav[2]); mul_b = sin_v; n_tag = TAG_RY;
                    end
                endcase
            end
            default: n_tag = TAG_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 2'd0;
            r_tag   <= TAG_NONE;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_tag   <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad[0] <= 16'd6656;
            r_rad[1] <= 16'd6656;
            r_rad[2] <= 16'd5632;
            r_dp     <= 1'b1;
            r_blend  <= 9'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEFT_RADIUS:  r_rad[0] <= i_cfg_data;
                CFG_RIGHT_RADIUS: r_rad[1] <= i_cfg_data;
                CFG_BACK_RADIUS:  r_rad[2] <= i_cfg_data;
                CFG_DRIVE_PAIR:   r_dp     <= i_cfg_data[0];
                CFG_FIX_BLEND:    r_blend  <= i_cfg_data[8:0];
                default:          r_dp     <= r_dp;
            endcase
        end
    end

    // tracked state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx    <= '0;
            r_ty    <= '0;
            r_held  <= '0;
            r_last[0] <= '0;
            r_last[1] <= '0;
            r_last[2] <= '0;
            r_lh    <= '0;
            r_phase <= PH_FIRST;
        end else begin
            if (accept) begin
                if (i_command) begin
                    r_phase <= PH_FIRST;
                end else if (!fuse_c) begin
                    r_phase <= (r_phase == PH_FIRST) ? PH_FUSE : PH_ENDED;
                end
            end
            if (r_state == S_MODF && r_cmd) begin
                r_lh <= h_new;
                r_tx <= r_fx;
                r_ty <= r_fy;
            end
            if (r_state == S_TE2) begin
                case (r_idx)
                    2'd0:    r_last[0] <= r_enc[0];
                    2'd1:    r_last[1] <= r_enc[1];
                    default: r_last[2] <= r_enc[2];
                endcase
            end
            if (r_state == S_FWD) begin
                r_lh <= r_h;
                if (r_dp) r_held <= 32'(fwd_sum >>> 1);
            end
            case (r_tag)
                TAG_BX: r_tx <= sat32(40'(bl_sh) + 40'(r_tx));
                TAG_BY: r_ty <= sat32(40'(bl_sh) + 40'(r_ty));
                TAG_RX: r_tx <= sat32(40'(rot_sh) + 40'(r_tx));
                TAG_RY: r_ty <= sat32(40'(rot_sh) + 40'(r_ty));
                default: begin
                end
            endcase
        end
    end

    // captured beat and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_command;
            r_fuse   <= fuse_c;
            r_enc[0] <= i_left_angle;
            r_enc[1] <= i_right_angle;
            r_enc[2] <= i_back_angle;
            r_fx     <= i_fix_x;
            r_fy     <= i_fix_y;
            if (i_command) begin
                r_angle <= i_fix_angle;
            end else if (fuse_c) begin
                r_angle <= 32'((33'(i_gyro_angle) + 33'(i_fix_angle)) >>> 1);
            end else begin
                r_angle <= i_gyro_angle;
            end
        end
        if (r_state == S_MODF) r_h <= h_new;
        if (r_state == S_FWD) r_flip <= flip_c;
        if (r_state == S_TE2) begin
            case (r_idx)
                2'd0:    r_trav[0] <= trav_v;
                2'd1:    r_trav[1] <= trav_v;
                default: r_trav[2] <= trav_v;
            endcase
        end
        case (r_tag)
            TAG_TMAG: begin
                if (three) begin
                    r_m <= 50'(r_prod[65] ? -r_prod : r_prod) * 50'd3;
                end else begin
                    r_m <= 50'(r_prod[65] ? -r_prod : r_prod);
                end
            end
            TAG_LOAD:  r_acc <= 82'(r_prod);
            TAG_ADDHI: r_acc <= r_acc + (82'(r_prod) <<< 25);
            TAG_RLOAD: r_acc <= 82'(r_prod) + (82'sd1 <<< 29);
            default:   r_acc <= r_acc;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_ox   <= r_tx;
            r_oy   <= r_ty;
            r_oang <= r_angle;
            r_ohw  <= r_cmd || r_fuse;
            r_omv  <= !r_cmd && ((r_held != 32'sd0) || (r_trav[2] != 32'sd0));
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_pos_x         = r_ox;
    assign o_pos_y         = r_oy;
    assign o_heading_out   = r_oang;
    assign o_heading_write = r_ohw;
    assign o_moved         = r_omv;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for wheel_gyro_odometry_tracker: directed and random
// tick/seed beats checked against an in-bench pose predictor. Depends on wgo_pkg.
`default_nettype none

module tb_top;
    import wgo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct {
        logic               cmd;
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] back;
        logic signed [31:0] gyro;
        logic               good;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fa;
    } sensor_beat_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] hdg;
        logic               hw;
        logic               mv;
    } pose_t;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_command;
    logic signed [31:0] i_left_angle, i_right_angle, i_back_angle, i_gyro_angle;
    logic               i_fix_good;
    logic signed [31:0] i_fix_x, i_fix_y, i_fix_angle;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_pos_x, o_pos_y, o_heading_out;
    logic               o_heading_write, o_moved;

    wheel_gyro_odometry_tracker dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [15:0]        rad_left, rad_right, rad_back;
    logic               pair_on;
    logic [8:0]         blend_cfg;
    logic signed [31:0] pr_x, pr_y, pr_left, pr_right, pr_back, pr_heading, pr_fwd;
    logic [1:0]         pr_phase;

    pose_t expected_poses[$];
    int    mismatches = 0;
    int    beats_sent = 0;
    int    poses_checked = 0;
    bit    idling_on = 1'b1;
    int    stall_left = 0;
    int    quiet_cycles = 0;

    longint atan_steps[32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // delta * radius * pi/2880 (times 3/4 for drive wheels), round half away
    function automatic logic signed [31:0] wheel_travel(longint delta, logic [15:0] rad,
                                                        bit drive);
        logic [127:0] mag;
        int           sh;
        longint       r;
        bit           neg;
        neg = delta < 0;
        mag = 128'(neg ? -delta : delta);
        mag = mag * rad;
        if (drive) mag = mag * 3;
        sh = drive ? 42 : 40;
        mag = mag * 128'(TRAVEL_K);
        mag = (mag + (128'd1 << (sh - 1))) >> sh;
        if (mag > 128'h80000000) mag = 128'h80000000;
        r = longint'(mag[63:0]);
        return clamp32(neg ? -r : r);
    endfunction

    task automatic heading_sincos(input longint ang, output longint c, output longint s);
        longint t, x, y, z, dx, dy;
        bit     flip;
        t = ((ang % TURN) + TURN) % TURN;
        flip = 1'b0;
        x = CORDIC_GAIN;
        y = 0;
        if (t > QUARTER && t < 3 * QUARTER) begin
            t = t - 2 * QUARTER;
            flip = 1'b1;
        end else if (t >= 3 * QUARTER) begin
            t = t - TURN;
        end
        z = t * 256;
        for (int i = 0; i < ROTATION_STEPS; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_steps[i & 31];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_steps[i & 31];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_pose(input sensor_beat_t b, output pose_t p);
        longint angle, fx, fy, fa, tx, ty, blend, h, mid, c, s, fwd, side;
        logic signed [31:0] dl, dr;
        fx = b.fx; fy = b.fy; fa = b.fa;
        p.hw = 1'b0;
        p.mv = 1'b0;
        if (b.cmd == CMD_SEED) begin
            pr_x = b.fx;
            pr_y = b.fy;
            pr_heading = 32'(fa % TURN);
            pr_phase = PH_FIRST;
            angle = fa;
            p.hw = 1'b1;
        end else begin
            angle = b.gyro;
            if (pr_phase == PH_FUSE && b.good) begin
                blend = (blend_cfg > BLEND_FULL) ? 256 : blend_cfg;
                angle = (angle + fa) >>> 1;
                p.hw = 1'b1;
                tx = pr_x; ty = pr_y;
                pr_x = clamp32(tx + (((fx - tx) * blend) >>> 8));
                pr_y = clamp32(ty + (((fy - ty) * blend) >>> 8));
            end else begin
                pr_phase = (pr_phase == PH_FIRST) ? PH_FUSE : PH_ENDED;
            end
            dl = wheel_travel(longint'(b.left) - pr_left, rad_left, 1'b1);
            dr = wheel_travel(longint'(b.right) - pr_right, rad_right, 1'b1);
            side = wheel_travel(longint'(b.back) - pr_back, rad_back, 1'b0);
            pr_left = b.left; pr_right = b.right; pr_back = b.back;
            if (pair_on) pr_fwd = clamp32((longint'(dl) + dr) >>> 1);
            fwd = pr_fwd;
            h = angle % TURN;
            mid = longint'(pr_heading) + ((h - pr_heading) >>> 1);
            pr_heading = 32'(h);
            heading_sincos(mid, c, s);
            tx = pr_x; ty = pr_y;
            pr_x = clamp32(tx + ((fwd * s + side * c + 64'sd536870912) >>> 30));
            pr_y = clamp32(ty + ((fwd * c - side * s + 64'sd536870912) >>> 30));
            p.mv = (fwd != 0 || side != 0);
        end
        p.x = pr_x;
        p.y = pr_y;
        p.hdg = angle[31:0];
    endtask

    task automatic send_beat(input sensor_beat_t b);
        pose_t p;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_command <= b.cmd;
        i_left_angle <= b.left;
        i_right_angle <= b.right;
        i_back_angle <= b.back;
        i_gyro_angle <= b.gyro;
        i_fix_good <= b.good;
        i_fix_x <= b.fx;
        i_fix_y <= b.fy;
        i_fix_angle <= b.fa;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_pose(b, p);
        expected_poses.push_back(p);
        beats_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] l, logic [15:0] r, logic [15:0] bk,
                              logic [15:0] pair, logic [15:0] blend);
        logic [15:0] vals[5];
        vals = '{l, r, bk, pair, blend};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        rad_left = l;
        rad_right = r;
        rad_back = bk;
        pair_on = pair[0];
        blend_cfg = blend[8:0];
    endtask

    function automatic sensor_beat_t noise_beat();
        sensor_beat_t b;
        b.cmd = 1'($urandom_range(0, 1));
        b.left = $urandom; b.right = $urandom; b.back = $urandom; b.gyro = $urandom;
        b.good = 1'($urandom_range(0, 1));
        b.fx = $urandom; b.fy = $urandom; b.fa = $urandom;
        return b;
    endfunction

    // small encoder and gyro steps with a fix close to the tracked pose
    function automatic sensor_beat_t drive_beat(bit seed);
        sensor_beat_t b;
        b.cmd = seed ? CMD_SEED : CMD_TICK;
        b.left = pr_left + $signed($urandom_range(0, 8000)) - 4000;
        b.right = pr_right + $signed($urandom_range(0, 8000)) - 4000;
        b.back = pr_back + $signed($urandom_range(0, 4000)) - 2000;
        b.gyro = pr_heading + $signed($urandom_range(0, 3000)) - 1500;
        b.good = ($urandom_range(0, 11) != 0);
        b.fx = pr_x + $signed($urandom_range(0, 400000)) - 200000;
        b.fy = pr_y + $signed($urandom_range(0, 400000)) - 200000;
        b.fa = b.gyro + $signed($urandom_range(0, 512)) - 256;
        return b;
    endfunction

    function automatic sensor_beat_t mk(logic cmd, int l, int r, int bk, int g,
                                        logic good, int fx, int fy, int fa);
        sensor_beat_t b;
        b = '{cmd, l, r, bk, g, good, fx, fy, fa};
        return b;
    endfunction

    task automatic test_directed();
        send_beat(mk(CMD_TICK, 0, 0, 0, 0, 1'b1, 0, 0, 0));
        send_beat(mk(CMD_TICK, 25600, 25600, 12800, 2560, 1'b1, 65536, 65536, 2300));
        send_beat(mk(CMD_TICK, 30000, 31000, 12000, 5000, 1'b0, 0, 0, 0));
        send_beat(mk(CMD_TICK, 30000, 31000, 12000, 5000, 1'b1, 0, 0, 0));
        // saturating wheel travel and position
        send_beat(mk(CMD_TICK, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     1'b1, 0, 0, 0));
        send_beat(mk(CMD_TICK, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                     1'b0, 0, 0, 0));
        send_beat(mk(CMD_SEED, 0, 0, 0, 0, 1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
        send_beat(mk(CMD_TICK, 0, 0, 0, 32'h80000000, 1'b1, 32'h80000000, 32'h7FFFFFFF,
                     32'h80000000));
        send_beat(mk(CMD_TICK, 100, 100, 100, -5000, 1'b1, 32'h80000000, 32'h7FFFFFFF,
                     32'h80000000));
        // heading wrap around a full turn
        send_beat(mk(CMD_SEED, 0, 0, 0, 0, 1'b1, 0, 0, 92000));
        send_beat(mk(CMD_TICK, 500, 500, 0, 92300, 1'b1, 0, 0, 92300));
        send_beat(mk(CMD_TICK, 900, 900, 0, 92300, 1'b1, 1000, 1000, 92320));
        send_beat(mk(CMD_TICK, 1200, 1300, 50, -46080, 1'b1, 0, 0, 46080));
        wait_drained();
        // drive pair absent, blend full and above range, zero and max radii
        write_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd256);
        send_beat(mk(CMD_SEED, 0, 0, 0, 0, 1'b1, 5000, -5000, 1000));
        send_beat(mk(CMD_TICK, 90000, -90000, 40000, 1100, 1'b1, 0, 0, 1000));
        send_beat(mk(CMD_TICK, 80000, -80000, -40000, 1200, 1'b1, 9000, 9000, 1300));
        wait_drained();
        write_regs(16'hFFFF, 16'd0, 16'd0, 16'd1, 16'h01FF);
        send_beat(mk(CMD_SEED, 0, 0, 0, 0, 1'b1, 0, 0, 0));
        send_beat(mk(CMD_TICK, 100000, 0, 0, 200, 1'b1, 0, 0, 0));
        send_beat(mk(CMD_TICK, 110000, 0, 7000, 400, 1'b1, 700000, -700000, 500));
        wait_drained();
        write_regs(16'd6656, 16'd6656, 16'd5632, 16'd1, 16'd0);
        send_beat(mk(CMD_SEED, 0, 0, 0, 0, 1'b1, 0, 0, 0));
        send_beat(mk(CMD_TICK, 0, 0, 0, 0, 1'b1, 0, 0, 0));
        send_beat(mk(CMD_TICK, 5000, 5000, 0, 0, 1'b1, 900000, 900000, 0));
        wait_drained();
    endtask

    task automatic test_random_phase(int count);
        int n;
        n = 0;
        while (n < count) begin
            case ($urandom_range(0, 19))
                0, 1:    send_beat(noise_beat());
                2:       send_beat(drive_beat(1'b1));
                default: send_beat(drive_beat(1'b0));
            endcase
            n++;
        end
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 6; ph++) begin
            write_regs(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                       16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 1)),
                       (ph == 2) ? 16'($urandom_range(257, 511))
                                 : 16'($urandom_range(0, 256)));
            test_random_phase(100);
        end
    endtask

    task automatic test_tail_no_idle();
        idling_on = 1'b0;
        write_regs(16'd6656, 16'd6656, 16'd5632, 16'd1, 16'd64);
        test_random_phase(120);
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        pose_t e;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (expected_poses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result beat at %0t", $realtime);
                end else begin
                    e = expected_poses.pop_front();
                    poses_checked++;
                    if (o_pos_x !== e.x || o_pos_y !== e.y || o_heading_out !== e.hdg ||
                        o_heading_write !== e.hw || o_moved !== e.mv) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch result %0d: exp x=%0d y=%0d h=%0d hw=%0b mv=%0b",
                                     poses_checked, e.x, e.y, e.hdg, e.hw, e.mv);
                            $display("                 got x=%0d y=%0d h=%0d hw=%0b mv=%0b",
                                     o_pos_x, o_pos_y, o_heading_out, o_heading_write, o_moved);
                        end
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_LEFT_RADIUS;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_ready <= 1'b0;
        i_command <= CMD_TICK;
        i_left_angle <= '0; i_right_angle <= '0; i_back_angle <= '0; i_gyro_angle <= '0;
        i_fix_good <= 1'b0;
        i_fix_x <= '0; i_fix_y <= '0; i_fix_angle <= '0;
        rad_left = 16'd6656; rad_right = 16'd6656; rad_back = 16'd5632;
        pair_on = 1'b1; blend_cfg = 9'd64;
        pr_x = '0; pr_y = '0; pr_left = '0; pr_right = '0; pr_back = '0;
        pr_heading = '0; pr_fwd = '0; pr_phase = PH_FIRST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_random_settings();
        test_tail_no_idle();

        i_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d sensor beats (ticks, seeds, fused and unfused) over 11 settings,",
                 beats_sent);
        $display("%0d result beats checked, %0d mismatches", poses_checked, mismatches);
        if (mismatches == 0 && expected_poses.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
